FILE: src/tabo_pkg.sv
// ----------------------------------------------------------------------------
// tabo_pkg
// Widths, codes and shared types of the triangle/box overlap test core.
// ----------------------------------------------------------------------------
package tabo_pkg;

    // coordinate width, Q16.16 signed
    localparam int CW      = 32;
    // vertex minus centre, and edge vectors
    localparam int DW      = CW + 1;
    // half extents, unsigned
    localparam int HW      = CW - 1;
    // one coordinate product and the difference of two
    localparam int PW      = 2 * DW;
    localparam int SW      = PW + 1;
    // edge axis radius: product and sum of two
    localparam int RPW     = HW + DW;
    localparam int RW      = RPW + 1;
    localparam int CMPW    = ((SW > RW) ? SW : RW) + 1;
    // normal component, signed, and its magnitude
    localparam int NW      = PW + 1;
    localparam int NMW     = NW - 1;
    // split of the magnitude for the radius products
    localparam int NLO     = NMW / 2;
    localparam int NHI     = NMW - NLO;
    // split of the signed component for the distance products
    localparam int NDL     = NW / 2;
    localparam int NDH     = NW - NDL;
    // final sums along the normal
    localparam int FW      = NW + DW + 2;

    localparam int NSTG    = 7;
    localparam int IN_TDW  = ((9 * CW + 7) / 8) * 8;
    localparam int OUT_TDW = 8;
    localparam int CFG_IW  = 3;

    typedef enum logic [CFG_IW-1:0] {
        CFG_CTR_X  = 0,
        CFG_CTR_Y  = 1,
        CFG_CTR_Z  = 2,
        CFG_HALF_X = 3,
        CFG_HALF_Y = 4,
        CFG_HALF_Z = 5
    } t_cfg_idx;

    typedef logic signed [DW-1:0] t_diff;

    typedef struct packed {
        logic [2:0][CW-1:0] ctr;
        logic [2:0][HW-1:0] half;
    } t_box;

    typedef struct packed {
        logic [NSTG-1:0] en;
        logic [NSTG-1:0] vld;
    } t_pipe_ctl;

endpackage

FILE: src/tabo_cfg.sv
// ----------------------------------------------------------------------------
// tabo_cfg
// Box register file: centre and half extents, written by index.
// ----------------------------------------------------------------------------
module tabo_cfg import tabo_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CW-1:0]     i_cfg_data,
    output t_box              o_box
);

    logic [2:0][CW-1:0] r_ctr;
    logic [2:0][HW-1:0] r_half;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr  <= '0;
            r_half <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_CTR_X:  r_ctr[0]  <= i_cfg_data;
                CFG_CTR_Y:  r_ctr[1]  <= i_cfg_data;
                CFG_CTR_Z:  r_ctr[2]  <= i_cfg_data;
                CFG_HALF_X: r_half[0] <= i_cfg_data[HW-1:0];
                CFG_HALF_Y: r_half[1] <= i_cfg_data[HW-1:0];
                CFG_HALF_Z: r_half[2] <= i_cfg_data[HW-1:0];
                default: ;
            endcase
        end
    end

    assign o_box.ctr  = r_ctr;
    assign o_box.half = r_half;

endmodule

FILE: src/tabo_ctrl.sv
// ----------------------------------------------------------------------------
// tabo_ctrl
// Valid bits and per-stage load enables of the test pipeline.
// ----------------------------------------------------------------------------
module tabo_ctrl import tabo_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_pipe_ctl o_ctl
);

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG-1:0] w_en;

    // a stage loads when it is empty or its request moves on
    always_comb begin
        w_en[NSTG-1] = !r_vld[NSTG-1] || i_out_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
        n_vld = r_vld;
        if (w_en[0]) begin
            n_vld[0] = i_in_valid;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (w_en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_vld[NSTG-1];
    assign o_ctl.en    = w_en;
    assign o_ctl.vld   = r_vld;

endmodule

FILE: src/tabo_front.sv
// ----------------------------------------------------------------------------
// tabo_front
// Vertices relative to the box centre, triangle edges, and the three box
// face axis tests.
// ----------------------------------------------------------------------------
module tabo_front import tabo_pkg::*; (
    input  logic              i_clk,
    input  t_pipe_ctl         i_ctl,
    input  t_box              i_box,
    input  logic [IN_TDW-1:0] i_tdata,
    output t_diff             o_v [3][3],
    output t_diff             o_f [3][3],
    output logic              o_face_sep
);

    t_diff       r_v [3][3];
    t_diff       r_f [3][3];
    t_diff       n_v [3][3];
    t_diff       n_f [3][3];
    logic        r_face_sep;
    logic        n_face_sep;

    // stage 1: shift to the box centre and form the edges
    always_comb begin
        logic signed [DW-1:0] w_vert [3][3];
        logic signed [DW-1:0] w_ctr;
        for (int d = 0; d < 3; d++) begin
            w_ctr = $signed({i_box.ctr[d][CW-1], i_box.ctr[d]});
            for (int i = 0; i < 3; i++) begin
                w_vert[i][d] = $signed({i_tdata[(i*3+d)*CW + CW - 1],
                                        i_tdata[(i*3+d)*CW +: CW]});
                n_v[i][d]    = w_vert[i][d] - w_ctr;
            end
            n_f[0][d] = w_vert[1][d] - w_vert[0][d];
            n_f[1][d] = w_vert[2][d] - w_vert[1][d];
            n_f[2][d] = w_vert[0][d] - w_vert[2][d];
        end
    end

    // stage 2: all three vertices beyond one face of the box
    always_comb begin
        logic signed [DW:0] w_hp;
        logic signed [DW:0] w_hn;
        logic signed [DW:0] w_vv;
        logic               w_lo;
        logic               w_hi;
        n_face_sep = 1'b0;
        for (int d = 0; d < 3; d++) begin
            w_hp = $signed({{(DW + 1 - HW){1'b0}}, i_box.half[d]});
            w_hn = -w_hp;
            w_lo = 1'b1;
            w_hi = 1'b1;
            for (int i = 0; i < 3; i++) begin
                w_vv = $signed({r_v[i][d][DW-1], r_v[i][d]});
                w_lo = w_lo && (w_vv < w_hn);
                w_hi = w_hi && (w_vv > w_hp);
            end
            n_face_sep = n_face_sep || w_lo || w_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r_v <= n_v;
            r_f <= n_f;
        end
        if (i_ctl.en[1]) begin
            r_face_sep <= n_face_sep;
        end
    end

    assign o_v        = r_v;
    assign o_f        = r_f;
    assign o_face_sep = r_face_sep;

endmodule

FILE: src/tabo_edge.sv
// ----------------------------------------------------------------------------
// tabo_edge
// The edge cross axes, each a triangle edge crossed with a box axis:
// products, projections and radii, then the strict separation compare.
// ----------------------------------------------------------------------------
module tabo_edge import tabo_pkg::*; (
    input  logic      i_clk,
    input  t_pipe_ctl i_ctl,
    input  t_box      i_box,
    input  t_diff     i_v [3][3],
    input  t_diff     i_f [3][3],
    output logic      o_edge_sep
);

    // the two box axes other than the one crossed with the edge
    localparam int CA [3] = '{1, 0, 0};
    localparam int CB [3] = '{2, 2, 1};
    // the two endpoints of an edge project alike; use one of them and the
    // opposite vertex
    localparam int VB [3] = '{2, 1, 1};

    logic signed [PW-1:0]  r_pa [3][3][2];
    logic signed [PW-1:0]  r_pb [3][3][2];
    logic        [RPW-1:0] r_ra [3][3];
    logic        [RPW-1:0] r_rb [3][3];
    logic signed [PW-1:0]  n_pa [3][3][2];
    logic signed [PW-1:0]  n_pb [3][3][2];
    logic        [RPW-1:0] n_ra [3][3];
    logic        [RPW-1:0] n_rb [3][3];

    logic signed [SW-1:0]  r_p [3][3][2];
    logic        [RW-1:0]  r_r [3][3];
    logic signed [SW-1:0]  n_p [3][3][2];
    logic        [RW-1:0]  n_r [3][3];

    logic                  r_edge_sep;
    logic                  n_edge_sep;

    // stage 2: projection and radius products
    always_comb begin
        logic [DW-1:0] w_mag [3][3];
        int            w_vi;
        for (int k = 0; k < 3; k++) begin
            for (int d = 0; d < 3; d++) begin
                w_mag[k][d] = i_f[k][d][DW-1] ? DW'(-i_f[k][d]) : DW'(i_f[k][d]);
            end
        end
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                for (int s = 0; s < 2; s++) begin
                    w_vi = (s == 0) ? 0 : VB[k];
                    n_pa[k][j][s] = i_v[w_vi][CB[j]] * i_f[k][CA[j]];
                    n_pb[k][j][s] = i_v[w_vi][CA[j]] * i_f[k][CB[j]];
                end
                n_ra[k][j] = i_box.half[CA[j]] * w_mag[k][CB[j]];
                n_rb[k][j] = i_box.half[CB[j]] * w_mag[k][CA[j]];
            end
        end
    end

    // stage 3: sums
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                for (int s = 0; s < 2; s++) begin
                    n_p[k][j][s] = $signed({r_pa[k][j][s][PW-1], r_pa[k][j][s]})
                                 - $signed({r_pb[k][j][s][PW-1], r_pb[k][j][s]});
                end
                n_r[k][j] = {1'b0, r_ra[k][j]} + {1'b0, r_rb[k][j]};
            end
        end
    end

    // stage 4: both projections beyond the radius on the same side
    always_comb begin
        logic signed [CMPW-1:0] w_rr;
        logic signed [CMPW-1:0] w_p0;
        logic signed [CMPW-1:0] w_p1;
        n_edge_sep = 1'b0;
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                w_rr = $signed({{(CMPW - RW){1'b0}}, r_r[k][j]});
                w_p0 = $signed({{(CMPW - SW){r_p[k][j][0][SW-1]}}, r_p[k][j][0]});
                w_p1 = $signed({{(CMPW - SW){r_p[k][j][1][SW-1]}}, r_p[k][j][1]});
                if ((w_p0 > w_rr && w_p1 > w_rr)
                    || ((w_p0 + w_rr) < 0 && (w_p1 + w_rr) < 0)) begin
                    n_edge_sep = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r_pa <= n_pa;
            r_pb <= n_pb;
            r_ra <= n_ra;
            r_rb <= n_rb;
        end
        if (i_ctl.en[2]) begin
            r_p <= n_p;
            r_r <= n_r;
        end
        if (i_ctl.en[3]) begin
            r_edge_sep <= n_edge_sep;
        end
    end

    assign o_edge_sep = r_edge_sep;

endmodule

FILE: src/tabo_normal.sv
// ----------------------------------------------------------------------------
// tabo_normal
// Triangle normal axis: cross product, split radius and distance products,
// recombination, and the final overlap decision.
// ----------------------------------------------------------------------------
module tabo_normal import tabo_pkg::*; (
    input  logic      i_clk,
    input  t_pipe_ctl i_ctl,
    input  t_box      i_box,
    input  t_diff     i_v0 [3],
    input  t_diff     i_f [3][3],
    input  logic      i_face_sep,
    input  logic      i_edge_sep,
    output logic      o_overlap
);

    localparam int NA [3] = '{1, 2, 0};
    localparam int NB [3] = '{2, 0, 1};
    localparam int RCW    = HW + NMW;
    localparam int DCW    = NW + DW;

    // stage 2
    logic signed [PW-1:0]          r_m1 [3];
    logic signed [PW-1:0]          r_m2 [3];
    t_diff                         r_v0_2 [3];
    // stage 3
    logic signed [NW-1:0]          r_n [3];
    logic        [NMW-1:0]         r_nmag [3];
    t_diff                         r_v0_3 [3];
    logic                          r_sep_3;
    logic signed [NW-1:0]          n_n [3];
    logic        [NMW-1:0]         n_nmag [3];
    // stage 4
    logic        [HW+NLO-1:0]      r_rlo [3];
    logic        [HW+NHI-1:0]      r_rhi [3];
    logic signed [NDL+DW:0]        r_dlo [3];
    logic signed [NDH+DW-1:0]      r_dhi [3];
    logic                          r_sep_4;
    // stage 5
    logic        [RCW-1:0]         r_rc [3];
    logic signed [DCW-1:0]         r_dc [3];
    logic                          r_sep_5;
    // stage 6
    logic        [FW-1:0]          r_rsum;
    logic signed [FW-1:0]          r_dsum;
    logic                          r_sep_6;
    // stage 7
    logic                          r_overlap;
    logic                          n_overlap;

    // stage 3: components and magnitudes of the normal
    always_comb begin
        logic signed [NW-1:0] w_d1;
        logic signed [NW-1:0] w_d2;
        for (int d = 0; d < 3; d++) begin
            w_d1 = $signed({r_m1[d][PW-1], r_m1[d]}) - $signed({r_m2[d][PW-1], r_m2[d]});
            w_d2 = $signed({r_m2[d][PW-1], r_m2[d]}) - $signed({r_m1[d][PW-1], r_m1[d]});
            n_n[d]    = w_d1;
            n_nmag[d] = w_d1[NW-1] ? w_d2[NMW-1:0] : w_d1[NMW-1:0];
        end
    end

    // stage 7: strict compare of the distance against the radius
    always_comb begin
        logic signed [FW-1:0] w_r;
        w_r       = $signed(r_rsum);
        n_overlap = !(r_sep_6 || (r_dsum > w_r) || ((r_dsum + w_r) < 0));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            for (int d = 0; d < 3; d++) begin
                r_m1[d] <= i_f[0][NA[d]] * i_f[1][NB[d]];
                r_m2[d] <= i_f[0][NB[d]] * i_f[1][NA[d]];
            end
            r_v0_2  <= i_v0;
        end
        if (i_ctl.en[2]) begin
            r_n     <= n_n;
            r_nmag  <= n_nmag;
            r_v0_3  <= r_v0_2;
            // the face flag already sits one stage in
            r_sep_3 <= i_face_sep;
        end
        if (i_ctl.en[3]) begin
            for (int d = 0; d < 3; d++) begin
                r_rlo[d] <= i_box.half[d] * r_nmag[d][NLO-1:0];
                r_rhi[d] <= i_box.half[d] * r_nmag[d][NMW-1:NLO];
                r_dlo[d] <= $signed({1'b0, r_n[d][NDL-1:0]}) * r_v0_3[d];
                r_dhi[d] <= $signed(r_n[d][NW-1:NDL]) * r_v0_3[d];
            end
            r_sep_4 <= r_sep_3;
        end
        if (i_ctl.en[4]) begin
            for (int d = 0; d < 3; d++) begin
                r_rc[d] <= {r_rhi[d], {NLO{1'b0}}} + RCW'(r_rlo[d]);
                r_dc[d] <= $signed({r_dhi[d], {NDL{1'b0}}})
                         + $signed({{(DCW - NDL - DW - 1){r_dlo[d][NDL+DW]}}, r_dlo[d]});
            end
            r_sep_5 <= r_sep_4 || i_edge_sep;
        end
        if (i_ctl.en[5]) begin
            r_rsum <= FW'(r_rc[0]) + FW'(r_rc[1]) + FW'(r_rc[2]);
            r_dsum <= $signed({{(FW - DCW){r_dc[0][DCW-1]}}, r_dc[0]})
                    + $signed({{(FW - DCW){r_dc[1][DCW-1]}}, r_dc[1]})
                    + $signed({{(FW - DCW){r_dc[2][DCW-1]}}, r_dc[2]});
            r_sep_6 <= r_sep_5;
        end
        if (i_ctl.en[6]) begin
            r_overlap <= n_overlap;
        end
    end

    assign o_overlap = r_overlap;

endmodule

FILE: src/triangle_aabb_overlap_test_core.sv
// ----------------------------------------------------------------------------
// triangle_aabb_overlap_test_core
// Separating axis test of one triangle against a configured box. Each
// request carries three vertices in signed Q16.16 and returns one flag that
// is 1 unless an axis (the cross of a triangle edge with a box axis, a box
// face, the triangle normal) separates the triangle from the box; touching
// counts as overlap. All arithmetic is exact, with no rounding or
// saturation. The core is a seven stage pipeline: one triangle enters every
// cycle while the output is not stalled, the depth being set by the
// chain of exact products along the normal axis (cross product, split
// products, recombination, sum, compare). A full stage holds only while the
// stage after it holds, so under an output stall requests keep entering
// until every stage holds one. The user must write box registers only
// while no request is in flight; the core itself does not enforce this.
// ----------------------------------------------------------------------------
module triangle_aabb_overlap_test_core import tabo_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // vert_a_x, vert_a_y, vert_a_z, vert_b_x .. vert_c_z, 32 bits each
    input  logic [IN_TDW-1:0]  s_axis_tdata,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // overlap in bit 0, zeros above
    output logic [OUT_TDW-1:0] m_axis_tdata,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CFG_IW-1:0]  i_cfg_index,
    input  logic [CW-1:0]      i_cfg_data
);

    t_box      w_box;
    t_pipe_ctl w_ctl;
    t_diff     w_v [3][3];
    t_diff     w_f [3][3];
    logic      w_face_sep;
    logic      w_edge_sep;
    logic      w_overlap;

    assign o_cfg_ready = 1'b1;

    tabo_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_box       (w_box)
    );

    tabo_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_ctl       (w_ctl)
    );

    tabo_front u_front (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl),
        .i_box      (w_box),
        .i_tdata    (s_axis_tdata),
        .o_v        (w_v),
        .o_f        (w_f),
        .o_face_sep (w_face_sep)
    );

    tabo_edge u_edge (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl),
        .i_box      (w_box),
        .i_v        (w_v),
        .i_f        (w_f),
        .o_edge_sep (w_edge_sep)
    );

    tabo_normal u_normal (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl),
        .i_box      (w_box),
        .i_v0       (w_v[0]),
        .i_f        (w_f),
        .i_face_sep (w_face_sep),
        .i_edge_sep (w_edge_sep),
        .o_overlap  (w_overlap)
    );

    assign m_axis_tdata = {{(OUT_TDW - 1){1'b0}}, w_overlap};

    // input is refused only when every stage holds a request
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (&w_ctl.vld))
        else $error("input refused with an empty pipeline stage");

    // an accepted request with nothing delivered adds exactly one entry
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && !(m_axis_tvalid && m_axis_tready))
        |=> ($countones(w_ctl.vld) == $past($countones(w_ctl.vld)) + 1))
        else $error("pipeline occupancy did not grow by one request");

    // a delivered result with nothing accepted removes exactly one entry
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !(s_axis_tvalid && s_axis_tready))
        |=> ($countones(w_ctl.vld) + 1 == $past($countones(w_ctl.vld))))
        else $error("pipeline occupancy did not drop by one request");

endmodule

FILE: tb/triangle_aabb_overlap_test_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_aabb_overlap_test_core_checker
// Watches the request, result and box register channels of the overlap core.
// Keeps its own copy of the box, works out the overlap flag of every accepted
// triangle with exact 128-bit arithmetic on all thirteen axes, and compares
// it with the flag that leaves the core, oldest request first.
// ----------------------------------------------------------------------------
module triangle_aabb_overlap_test_core_checker import tabo_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [IN_TDW-1:0]  i_req_data,
    input  logic               i_req_valid,
    input  logic               i_req_ready,
    input  logic [OUT_TDW-1:0] i_res_data,
    input  logic               i_res_valid,
    input  logic               i_res_ready,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [CFG_IW-1:0]  i_cfg_index,
    input  logic [CW-1:0]      i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_overlaps,
    output int                 o_separations
);

    typedef logic signed [127:0] t_wide;

    t_wide box_ctr  [3];
    t_wide box_half [3];
    logic  overlap_flags_due [$];

    function automatic t_wide mag(input t_wide x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic t_wide max3(input t_wide a, input t_wide b, input t_wide c);
        t_wide m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    function automatic t_wide min3(input t_wide a, input t_wide b, input t_wide c);
        t_wide m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic t_wide dot3(input t_wide ax, input t_wide ay, input t_wide az,
                                   input t_wide bx, input t_wide by, input t_wide bz);
        return ax * bx + ay * by + az * bz;
    endfunction

    // the projections lie wholly beyond the box radius on one side
    function automatic logic apart(input t_wide p0, input t_wide p1, input t_wide p2,
                                   input t_wide radius);
        t_wide hi, lo, reach;
        hi    = max3(p0, p1, p2);
        lo    = min3(p0, p1, p2);
        reach = (-hi > lo) ? -hi : lo;
        return radius < reach;
    endfunction

    function automatic logic box_overlap_flag(input logic [IN_TDW-1:0] data);
        t_wide raw  [9];
        t_wide rel  [9];
        t_wide side [9];
        t_wide p    [3];
        t_wide fx, fy, fz, ax, ay, az, r, nx, ny, nz;
        logic  split;
        int    i, j, k, n, d;
        split = 1'b0;
        for (n = 0; n < 9; n++) begin
            raw[n] = $signed(data[n*CW +: CW]);
            rel[n] = raw[n] - box_ctr[n % 3];
        end
        for (d = 0; d < 3; d++) begin
            side[d]     = raw[3 + d] - raw[d];
            side[3 + d] = raw[6 + d] - raw[3 + d];
            side[6 + d] = raw[d] - raw[6 + d];
        end
        // edge cross axes
        for (k = 0; k < 3; k++) begin
            fx = side[k*3];
            fy = side[k*3 + 1];
            fz = side[k*3 + 2];
            for (j = 0; j < 3; j++) begin
                case (j)
                    0: begin
                        ax = 0;
                        ay = -fz;
                        az = fy;
                        r  = box_half[1] * mag(fz) + box_half[2] * mag(fy);
                    end
                    1: begin
                        ax = fz;
                        ay = 0;
                        az = -fx;
                        r  = box_half[0] * mag(fz) + box_half[2] * mag(fx);
                    end
                    default: begin
                        ax = -fy;
                        ay = fx;
                        az = 0;
                        r  = box_half[0] * mag(fy) + box_half[1] * mag(fx);
                    end
                endcase
                for (i = 0; i < 3; i++)
                    p[i] = dot3(ax, ay, az, rel[i*3], rel[i*3 + 1], rel[i*3 + 2]);
                if (apart(p[0], p[1], p[2], r))
                    split = 1'b1;
            end
        end
        // box faces
        for (d = 0; d < 3; d++) begin
            if (max3(rel[d], rel[3 + d], rel[6 + d]) < -box_half[d] ||
                box_half[d] < min3(rel[d], rel[3 + d], rel[6 + d]))
                split = 1'b1;
        end
        // triangle normal
        nx = side[1] * side[5] - side[2] * side[4];
        ny = side[2] * side[3] - side[0] * side[5];
        nz = side[0] * side[4] - side[1] * side[3];
        r  = box_half[0] * mag(nx) + box_half[1] * mag(ny) + box_half[2] * mag(nz);
        if (r < mag(dot3(nx, ny, nz, rel[0], rel[1], rel[2])))
            split = 1'b1;
        return !split;
    endfunction

    always @(posedge i_clk) begin : watch
        logic want;
        int   fails, hits, misses, d;
        if (!i_rst_n) begin
            for (d = 0; d < 3; d++) begin
                box_ctr[d]  = 0;
                box_half[d] = 0;
            end
            overlap_flags_due.delete();
            fails  = 0;
            hits   = 0;
            misses = 0;
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (overlap_flags_due.size() == 0) begin
                    $error("overlap: no triangle outstanding, got %0d", i_res_data[0]);
                    fails++;
                end else begin
                    want = overlap_flags_due.pop_front();
                    if (i_res_data[0] !== want) begin
                        $error("overlap mismatch: expected %0d, got %0d", want, i_res_data[0]);
                        fails++;
                    end
                    if (i_res_data[OUT_TDW-1:1] !== '0) begin
                        $error("tdata padding mismatch: expected 0, got %0h",
                               i_res_data[OUT_TDW-1:1]);
                        fails++;
                    end
                end
            end
            // spare indexes fall through both ranges and are dropped
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index <= CFG_CTR_Z)
                    box_ctr[i_cfg_index] = $signed(i_cfg_data);
                else if (i_cfg_index <= CFG_HALF_Z)
                    box_half[i_cfg_index - CFG_HALF_X] = $signed({1'b0, i_cfg_data[HW-1:0]});
            end
            if (i_req_valid && i_req_ready) begin
                want = box_overlap_flag(i_req_data);
                overlap_flags_due.push_back(want);
                if (want)
                    hits++;
                else
                    misses++;
            end
        end
        o_fail_count  <= fails;
        o_pending     <= overlap_flags_due.size();
        o_overlaps    <= hits;
        o_separations <= misses;
    end

endmodule

FILE: tb/triangle_aabb_overlap_test_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_aabb_overlap_test_core_tb
// Drives triangles and box settings into the overlap core with random gaps
// and output stalls: a directed set first (touching faces, point boxes,
// degenerate and extreme triangles, axes that alone separate), then phases
// of random triangles around boxes of many sizes. The checker does the
// comparing; this module gives the verdict.
// ----------------------------------------------------------------------------
module triangle_aabb_overlap_test_core_tb import tabo_pkg::*; ();

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 6;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 110;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int ONE             = 65536;
    localparam int COORD_MAX       = 32'sh7FFF_FFFF;
    localparam int COORD_MIN       = 32'sh8000_0000;
    localparam logic [CW-1:0] HALF_MAX = 32'h7FFF_FFFF;
    localparam logic [CFG_IW-1:0] CFG_SPARE_LO = CFG_HALF_Z + 1;
    localparam logic [CFG_IW-1:0] CFG_SPARE_HI = CFG_HALF_Z + 2;

    typedef enum int {BOX_SMALL, BOX_WIDE, BOX_POINT, BOX_EXTREME, BOX_ROOMY} t_box_mode;
    typedef enum int {SHAPE_NEAR, SHAPE_TOUCH, SHAPE_FLAT, SHAPE_NOISE, SHAPE_SLIVER} t_shape;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic [IN_TDW-1:0]  s_axis_tdata;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [OUT_TDW-1:0] m_axis_tdata;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [CFG_IW-1:0]  i_cfg_index;
    logic [CW-1:0]      i_cfg_data;

    int     fail_count, pending, overlaps, separations;
    int     cycles   = 0;
    int     items    = 0;
    int     settings = 0;
    bit     idle_on  = 1'b1;
    bit     stall_on = 1'b1;
    longint box_ctr_q  [3] = '{0, 0, 0};
    longint box_half_q [3] = '{0, 0, 0};

    triangle_aabb_overlap_test_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    triangle_aabb_overlap_test_core_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_data    (s_axis_tdata),
        .i_req_valid   (s_axis_tvalid),
        .i_req_ready   (s_axis_tready),
        .i_res_data    (m_axis_tdata),
        .i_res_valid   (m_axis_tvalid),
        .i_res_ready   (m_axis_tready),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_overlaps    (overlaps),
        .o_separations (separations)
    );

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("** triangle_aabb_overlap_test_core: FAILED **");
            $finish;
        end
    end

    function automatic logic [IN_TDW-1:0] pack_facet(input int ax, input int ay, input int az,
                                                     input int bx, input int by, input int bz,
                                                     input int cx, input int cy, input int cz);
        return {cz, cy, cx, bz, by, bx, az, ay, ax};
    endfunction

    function automatic logic [IN_TDW-1:0] random_facet();
        logic [CW-1:0]     c [9];
        logic [IN_TDW-1:0] data;
        longint            span, off, sum;
        int                roll, n, d;
        t_shape            shape;
        roll  = $urandom_range(0, 19);
        shape = (roll < 12) ? SHAPE_NEAR  : (roll < 14) ? SHAPE_TOUCH :
                (roll < 16) ? SHAPE_FLAT  : (roll < 18) ? SHAPE_NOISE : SHAPE_SLIVER;
        for (n = 0; n < 9; n++) begin
            d    = n % 3;
            span = 3 * box_half_q[d] + 2 * ONE;
            if (span > 64'sh7FFF_FFFF)
                span = 64'sh7FFF_FFFF;
            off  = longint'($urandom) % (2 * span + 1) - span;
            sum  = box_ctr_q[d] + off;
            c[n] = sum[CW-1:0];
        end
        case (shape)
            SHAPE_TOUCH: begin
                // pin all three vertices to one face plane
                d   = $urandom_range(0, 2);
                sum = $urandom_range(0, 1) ? box_ctr_q[d] + box_half_q[d]
                                           : box_ctr_q[d] - box_half_q[d];
                for (n = 0; n < 3; n++)
                    c[n*3 + d] = sum[CW-1:0];
            end
            SHAPE_FLAT: begin
                roll = $urandom_range(0, 1);
                for (d = 0; d < 3; d++) begin
                    c[3 + d] = c[d];
                    if (roll != 0)
                        c[6 + d] = c[d];
                end
            end
            SHAPE_NOISE: begin
                for (n = 0; n < 9; n++)
                    c[n] = $urandom;
            end
            SHAPE_SLIVER: begin
                // small triangle hugging the first vertex
                for (n = 3; n < 9; n++) begin
                    d    = n % 3;
                    span = box_half_q[d] / 4 + ONE / 4;
                    off  = longint'($urandom) % (2 * span + 1) - span;
                    sum  = longint'(signed'(c[d])) + off;
                    c[n] = sum[CW-1:0];
                end
            end
            default: ;
        endcase
        for (n = 0; n < 9; n++)
            data[n*CW +: CW] = c[n];
        return data;
    endfunction

    task automatic send_triangle(input logic [IN_TDW-1:0] data);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        do @(posedge i_clk); while (!s_axis_tready);
        items++;
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CW-1:0] value);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            i_cfg_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx <= CFG_CTR_Z)
            box_ctr_q[idx] = longint'(signed'(value));
        else if (idx <= CFG_HALF_Z)
            box_half_q[idx - CFG_HALF_X] = longint'(value[HW-1:0]);
    endtask

    // drain the pipeline, then load a new box
    task automatic apply_box(input logic [CW-1:0] cx, input logic [CW-1:0] cy,
                             input logic [CW-1:0] cz, input logic [CW-1:0] hx,
                             input logic [CW-1:0] hy, input logic [CW-1:0] hz,
                             input bit with_spares);
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        write_reg(CFG_CTR_X, cx);
        write_reg(CFG_CTR_Y, cy);
        write_reg(CFG_CTR_Z, cz);
        write_reg(CFG_HALF_X, hx);
        write_reg(CFG_HALF_Y, hy);
        write_reg(CFG_HALF_Z, hz);
        if (with_spares || $urandom_range(0, 2) == 0) begin
            write_reg(CFG_SPARE_LO, $urandom);
            write_reg(CFG_SPARE_HI, $urandom);
        end
        i_cfg_valid <= 1'b0;
        settings++;
    endtask

    initial begin : sink
        int stall, seen;
        seen = 0;
        m_axis_tready <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        forever begin
            stall = stall_on ? $urandom_range(0, 4) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            seen++;
            if (seen % 64 == 0)
                stall_on = ($urandom_range(0, 3) != 0);
        end
    end

    initial begin : source
        logic [CW-1:0] bc [3];
        logic [CW-1:0] bh [3];
        logic [CW-1:0] ends [3];
        t_box_mode     mode;
        int            p, n, d;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        ends[0] = COORD_MIN;
        ends[1] = COORD_MAX;
        ends[2] = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // box from reset is a single point at the origin
        send_triangle(pack_facet(-ONE, -ONE, 0, ONE, -ONE, 0, 0, ONE, 0));
        send_triangle(pack_facet(ONE, ONE, ONE, 2*ONE, ONE, ONE, ONE, 2*ONE, ONE));

        apply_box(0, 0, 0, ONE, ONE, ONE, 1'b0);
        send_triangle(pack_facet(ONE/4, 0, 0, 0, ONE/4, 0, 0, 0, ONE/4));
        send_triangle(pack_facet(ONE, 0, 0, ONE, ONE/2, 0, ONE, 0, ONE/2));
        send_triangle(pack_facet(ONE+1, 0, 0, ONE+1, ONE/2, 0, ONE+1, 0, ONE/2));
        // clears the box only along an edge cross axis
        send_triangle(pack_facet(0, 5*ONE/2, 0, 5*ONE/2, 0, 0, 5*ONE/2, 5*ONE/2, 0));
        // large slanted triangle beyond the box corner along its normal
        send_triangle(pack_facet(10*ONE, -13*ONE/4, -13*ONE/4, -13*ONE/4, 10*ONE, -13*ONE/4,
                                 -13*ONE/4, -13*ONE/4, 10*ONE));
        send_triangle(pack_facet(ONE/2, ONE/2, ONE/2, ONE/2, ONE/2, ONE/2,
                                 ONE/2, ONE/2, ONE/2));
        send_triangle(pack_facet(3*ONE, 0, 0, 3*ONE, 0, 0, 3*ONE, 0, 0));
        send_triangle(pack_facet(-5*ONE, 0, 0, 0, 0, 0, 5*ONE, 0, 0));
        send_triangle(pack_facet(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                                 COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        send_triangle(pack_facet(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                                 COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
        send_triangle(pack_facet(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN,
                                 COORD_MAX, 0, 0, 0));

        // extreme box; top half-extent bit set to check it is dropped
        apply_box(COORD_MIN, COORD_MAX, 0, 32'hFFFF_FFFF, 0, HALF_MAX, 1'b1);
        send_triangle(pack_facet(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                                 COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        send_triangle(pack_facet(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                                 COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
        send_triangle(pack_facet(COORD_MIN, COORD_MAX, 0, COORD_MIN, COORD_MAX, 0,
                                 COORD_MIN, COORD_MAX, 0));
        send_triangle(pack_facet(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX,
                                 COORD_MAX, COORD_MIN, COORD_MIN, 0));

        for (p = 0; p < RANDOM_PHASES; p++) begin
            mode = (p < 5) ? t_box_mode'(p) : t_box_mode'($urandom_range(0, 4));
            for (d = 0; d < 3; d++) begin
                bc[d] = $urandom_range(0, 32*ONE) - 16*ONE;
                case (mode)
                    BOX_SMALL:   bh[d] = $urandom_range(0, 4*ONE);
                    BOX_POINT:   bh[d] = '0;
                    BOX_ROOMY:   bh[d] = $urandom_range(0, 64*ONE);
                    BOX_WIDE: begin
                        bc[d] = $urandom;
                        bh[d] = $urandom;
                    end
                    default: begin
                        bc[d] = ends[$urandom_range(0, 2)];
                        bh[d] = $urandom_range(0, 1) ? HALF_MAX : '0;
                        bh[d][CW-1] = $urandom_range(0, 1);
                    end
                endcase
            end
            apply_box(bc[0], bc[1], bc[2], bh[0], bh[1], bh[2], 1'b0);
            idle_on = ($urandom_range(0, 3) != 0);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
                send_triangle(random_facet());
        end

        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (NSTG + 4) @(posedge i_clk);
        $display("Ran %0d triangles over %0d box settings, touching and extreme cases included.",
                 items, settings);
        $display("Seen %0d overlapping and %0d separated triangles.", overlaps, separations);
        if (fail_count == 0)
            $display("** triangle_aabb_overlap_test_core: PASSED **");
        else
            $display("** triangle_aabb_overlap_test_core: FAILED **");
        $finish;
    end

endmodule

FILE: filelist.f
src/tabo_pkg.sv
src/tabo_cfg.sv
src/tabo_ctrl.sv
src/tabo_front.sv
src/tabo_edge.sv
src/tabo_normal.sv
src/triangle_aabb_overlap_test_core.sv
tb/triangle_aabb_overlap_test_core_checker.sv
tb/triangle_aabb_overlap_test_core_tb.sv
